// ===== rtl/mvrc_pkg.sv =====
// Shared types and constants for the motor voltage ramp controller.
// Holds the sequencer state type, fixed-point widths and limit constants.
// No dependencies.
package mvrc_pkg;

   // Fraction bits of every voltage quantity
   localparam int VOLT_FRAC_BITS = 8;

   // Field widths
   localparam int VOLT_W  = 24;
   localparam int SUP_W   = 23;
   localparam int RATIO_W = 16;
   localparam int ILIM_W  = 16;
   localparam int STEP_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int ISET_W  = 17;
   localparam int DUTY_W  = 16;

   // Internal working widths
   localparam int WIDE_W = 26;
   localparam int ACC_W  = 42;
   localparam int MAG_W  = 25;

   // Serial unit lengths: one multiplier bit or one quotient bit per cycle
   localparam int MUL_STEPS = RATIO_W;
   localparam int DIV_STEPS = DUTY_W;
   localparam int CNT_W     = $clog2(MUL_STEPS);

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;
   localparam logic [DUTY_W-1:0] DUTY_MAX   = 16'd49152;

   localparam logic signed [WIDE_W-1:0] ONE_VOLT = WIDE_W'(1) << VOLT_FRAC_BITS;
   localparam logic signed [WIDE_W-1:0] V24_MAX  = WIDE_W'(8388607);
   localparam logic signed [WIDE_W-1:0] V24_MIN  = -WIDE_W'(8388608);

   // Rounding offsets for the two fixed-point products
   localparam logic signed [ACC_W-1:0] EMF_ROUND  = ACC_W'(16384);
   localparam logic signed [ACC_W-1:0] FILT_ROUND = ACC_W'(32768);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_EMF,
      ST_EMF_DIFF,
      ST_MUL_FILT,
      ST_FILTER,
      ST_RAMP,
      ST_DIV_SETUP,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

endpackage

// ===== rtl/motor_voltage_ramp_controller.sv =====
// Motor voltage ramp controller: one result per request, computed serially.
// Each request runs through one shared shift-add multiplier, used twice over
// 16 multiplier bits, and then a restoring divider producing one duty bit per
// cycle; the divider is skipped when the duty is forced to 0.75 (snap, zero
// supply, zero current limit or |v| >= supply). A finished result is held in
// an output register, so the next request is taken while it waits. The user
// must write filter_gain through csr_we and csr_wdata only while the block is
// idle; the block itself does not enforce this. Depends on mvrc_pkg.
module motor_voltage_ramp_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,     // filter_gain
   input  logic        req_tvalid,
   output logic        req_tready,
   // target_voltage[23:0], supply_voltage[46:24], rotor_ratio[62:47],
   // current_limit[78:63], ramp_step[94:79], zero[95]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // current_setpoint[16:0], duty_limit[32:17], speed_reached[33], zero[39:34]
   output logic [39:0] rsp_tdata
);
   import mvrc_pkg::*;

   // Sequencer
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Serial multiplier
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [WIDE_W-1:0] mcand_ff, mcand_in;
   logic [RATIO_W-1:0]       mplier_ff, mplier_in;
   logic                     sgn_mode_ff, sgn_mode_in;

   // Latched request
   logic signed [VOLT_W-1:0] target_ff, target_in;
   logic [SUP_W-1:0]         supply_ff, supply_in;
   logic [ILIM_W-1:0]        ilim_ff, ilim_in;
   logic [STEP_W-1:0]        step_ff, step_in;

   // Persistent state and configuration
   logic signed [VOLT_W-1:0] ramp_ff, ramp_in;
   logic signed [VOLT_W-1:0] filt_ff, filt_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;

   // Per-request results
   logic                     speed_ff, speed_in;
   logic signed [ISET_W-1:0] iset_ff, iset_in;
   logic                     force_ff, force_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [SUP_W-1:0]         rem_ff, rem_in;
   logic [DUTY_W-1:0]        quo_ff, quo_in;

   // Output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ISET_W-1:0] rsp_iset_ff, rsp_iset_in;
   logic [DUTY_W-1:0]        rsp_duty_ff, rsp_duty_in;
   logic                     rsp_speed_ff, rsp_speed_in;

   // Combinational helpers
   logic                     req_fire;
   logic                     cnt_last;
   logic                     rsp_free;
   logic                     div_skip;
   logic signed [ACC_W-1:0]  mc_ext, addend;
   logic signed [ACC_W-1:0]  emf_sum, filt_sum;
   logic signed [MAG_W-1:0]  emf;
   logic signed [WIDE_W-1:0] emf_diff;
   logic signed [WIDE_W-1:0] inc;
   logic signed [WIDE_W:0]   nf_sum;
   logic signed [VOLT_W-1:0] nf_sat;
   logic signed [WIDE_W-1:0] v26, t26, f26, step26, up26, dn26, dn_sat;
   logic signed [WIDE_W-1:0] vn, dv, dmag, dspeed;
   logic signed [ISET_W-1:0] ilim_pos, ilim_neg, iset_calc;
   logic                     snap;
   logic [SUP_W:0]           r2, rsub;
   logic                     r_ge;
   logic [DUTY_W-1:0]        duty_sat;

   assign req_fire = req_tvalid && req_tready;
   assign cnt_last = (cnt_ff == CNT_W'(MUL_STEPS - 1));
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign div_skip = force_ff || (mag_ff >= {2'b00, supply_ff});

   // Multiplier step: MSB first, sign bit subtracts in signed mode
   assign mc_ext = {{(ACC_W-WIDE_W){mcand_ff[WIDE_W-1]}}, mcand_ff};
   always_comb begin
      if (!mplier_ff[RATIO_W-1]) begin
         addend = '0;
      end else if (sgn_mode_ff && cnt_ff == '0) begin
         addend = -mc_ext;
      end else begin
         addend = mc_ext;
      end
   end

   // Back-EMF rounding and filter difference
   assign emf_sum  = acc_ff + EMF_ROUND;
   assign emf      = emf_sum[MAG_W+14:15];
   assign emf_diff = {emf[MAG_W-1], emf} - {{(WIDE_W-VOLT_W){filt_ff[VOLT_W-1]}}, filt_ff};

   // Filter increment, accumulate and saturate
   assign filt_sum = acc_ff + FILT_ROUND;
   assign inc      = filt_sum[WIDE_W+15:16];
   assign nf_sum   = {inc[WIDE_W-1], inc} +
                     {{(WIDE_W+1-VOLT_W){filt_ff[VOLT_W-1]}}, filt_ff};
   always_comb begin
      if (nf_sum > $signed({V24_MAX[WIDE_W-1], V24_MAX})) begin
         nf_sat = V24_MAX[VOLT_W-1:0];
      end else if (nf_sum < $signed({V24_MIN[WIDE_W-1], V24_MIN})) begin
         nf_sat = V24_MIN[VOLT_W-1:0];
      end else begin
         nf_sat = nf_sum[VOLT_W-1:0];
      end
   end

   // Ramp step operands
   assign v26      = {{(WIDE_W-VOLT_W){ramp_ff[VOLT_W-1]}}, ramp_ff};
   assign t26      = {{(WIDE_W-VOLT_W){target_ff[VOLT_W-1]}}, target_ff};
   assign f26      = {{(WIDE_W-VOLT_W){filt_ff[VOLT_W-1]}}, filt_ff};
   assign step26   = {{(WIDE_W-STEP_W){1'b0}}, step_ff};
   assign up26     = v26 + step26;
   assign dn26     = v26 - step26;
   assign dn_sat   = (dn26 < V24_MIN) ? V24_MIN : dn26;
   assign ilim_pos = {1'b0, ilim_ff};
   assign ilim_neg = -ilim_pos;

   // Ramp toward the setpoint, snapping to the filtered value on a far-side start
   always_comb begin
      snap      = 1'b0;
      vn        = v26;
      dv        = v26;
      iset_calc = (v26 < 0) ? ilim_neg : ilim_pos;
      if (t26 > v26) begin
         if (v26 < -ONE_VOLT) begin
            snap = 1'b1;
            vn   = f26;
         end else begin
            vn        = up26;
            dv        = up26;
            iset_calc = ilim_pos;
         end
         if (vn > t26) begin
            vn = t26;
         end
      end else if (t26 < v26) begin
         if (v26 > ONE_VOLT) begin
            snap = 1'b1;
            vn   = f26;
         end else begin
            vn        = dn_sat;
            dv        = dn_sat;
            iset_calc = ilim_neg;
         end
      end
      if (snap) begin
         iset_calc = '0;
      end
   end

   assign dmag   = (dv < 0) ? -dv : dv;
   assign dspeed = f26 - t26;

   // Restoring divider step
   assign r2       = {rem_ff, 1'b0};
   assign r_ge     = (r2 >= {1'b0, supply_ff});
   assign rsub     = r2 - {1'b0, supply_ff};
   assign duty_sat = (force_ff || quo_ff > DUTY_MAX) ? DUTY_MAX : quo_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_MUL_EMF;
            end
         end
         ST_MUL_EMF: begin
            if (cnt_last) begin
               state_in = ST_EMF_DIFF;
            end
         end
         ST_EMF_DIFF: state_in = ST_MUL_FILT;
         ST_MUL_FILT: begin
            if (cnt_last) begin
               state_in = ST_FILTER;
            end
         end
         ST_FILTER:    state_in = ST_RAMP;
         ST_RAMP:      state_in = ST_DIV_SETUP;
         ST_DIV_SETUP: state_in = div_skip ? ST_OUTPUT : ST_DIVIDE;
         ST_DIVIDE: begin
            if (cnt_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      req_tready   = (state_ff == ST_IDLE);
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      sgn_mode_in  = sgn_mode_ff;
      target_in    = target_ff;
      supply_in    = supply_ff;
      ilim_in      = ilim_ff;
      step_in      = step_ff;
      ramp_in      = ramp_ff;
      filt_in      = filt_ff;
      gain_in      = csr_we ? csr_wdata : gain_ff;
      speed_in     = speed_ff;
      iset_in      = iset_ff;
      force_in     = force_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_iset_in  = rsp_iset_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_speed_in = rsp_speed_ff;
      case (state_ff)
         ST_IDLE: begin
            // Latch the request and load the back-EMF product
            if (req_fire) begin
               target_in   = req_tdata[23:0];
               supply_in   = req_tdata[46:24];
               mplier_in   = req_tdata[62:47];
               ilim_in     = req_tdata[78:63];
               step_in     = req_tdata[94:79];
               mcand_in    = {{(WIDE_W-SUP_W){1'b0}}, req_tdata[46:24]};
               sgn_mode_in = 1'b1;
               acc_in      = '0;
               cnt_in      = '0;
            end
         end
         ST_MUL_EMF, ST_MUL_FILT: begin
            // Advance one multiplier bit
            acc_in    = (acc_ff <<< 1) + addend;
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         ST_EMF_DIFF: begin
            // Load the filter product
            mcand_in    = emf_diff;
            mplier_in   = gain_ff;
            sgn_mode_in = 1'b0;
            acc_in      = '0;
            cnt_in      = '0;
         end
         ST_FILTER: begin
            filt_in = nf_sat;
         end
         ST_RAMP: begin
            ramp_in  = vn[VOLT_W-1:0];
            iset_in  = iset_calc;
            mag_in   = dmag[MAG_W-1:0];
            force_in = snap || (ilim_ff == '0) || (supply_ff == '0);
            speed_in = (dspeed > -ONE_VOLT) && (dspeed < ONE_VOLT);
         end
         ST_DIV_SETUP: begin
            // Quotient of 2^16 or more saturates at once
            if (div_skip) begin
               force_in = 1'b1;
            end else begin
               rem_in = mag_ff[SUP_W-1:0];
               quo_in = '0;
               cnt_in = '0;
            end
         end
         ST_DIVIDE: begin
            // One quotient bit per cycle
            rem_in = r_ge ? rsub[SUP_W-1:0] : r2[SUP_W-1:0];
            quo_in = {quo_ff[DUTY_W-2:0], r_ge};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_OUTPUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_iset_in  = iset_ff;
               rsp_duty_in  = duty_sat;
               rsp_speed_in = speed_ff;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ramp_ff      <= '0;
         filt_ff      <= '0;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ramp_ff      <= ramp_in;
         filt_ff      <= filt_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      sgn_mode_ff  <= sgn_mode_in;
      target_ff    <= target_in;
      supply_ff    <= supply_in;
      ilim_ff      <= ilim_in;
      step_ff      <= step_in;
      speed_ff     <= speed_in;
      iset_ff      <= iset_in;
      force_ff     <= force_in;
      mag_ff       <= mag_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      rsp_iset_ff  <= rsp_iset_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_speed_ff, rsp_duty_ff, rsp_iset_ff};

endmodule

// ===== rtl/mvrc_checker.sv =====
// Port-level checks for the motor voltage ramp controller.
// Depends on mvrc_pkg; bound to motor_voltage_ramp_controller below.
module mvrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import mvrc_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Duty never above 0.75
   a_duty_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[32:17] <= DUTY_MAX)
      else $error("duty above limit");

   // Zero current command always comes with full duty limit
   a_zero_iset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16:0] == '0 |-> rsp_tdata[32:17] == DUTY_MAX)
      else $error("zero current without forced duty");

   // One request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind motor_voltage_ramp_controller mvrc_checker u_mvrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
